>>> rtl/qtc_pkg.sv
// Shared types, constants and pipeline stage positions for the quaternion codec.
// Depends on nothing; every other file but qtc_isqrt takes its names through qtc_pkg::.
package qtc_pkg;

  // Code range that encoded components saturate to
  localparam int CODE_BITS = 16;
  localparam logic signed [31:0] CODE_HI = (32'sd1 <<< (CODE_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] CODE_LO = -CODE_HI - 32'sd1;

  localparam logic [14:0] SCALE_RST = 15'd32767;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

  // Pipeline positions, counted in clock edges after the input transfer
  localparam int LANE_DIV_STAGES = 16;
  localparam int LANE_LAT        = LANE_DIV_STAGES + 2;
  localparam int RAD_IDX         = LANE_LAT + 1;
  localparam int RAD_W           = 31;
  localparam int ROOT_W          = (RAD_W + 1) / 2;
  localparam int XROOT_IDX       = RAD_IDX + ROOT_W;
  localparam int NORM_IDX        = XROOT_IDX + 1;
  localparam int NSQ_IN_W        = 62;
  localparam int N_W             = (NSQ_IN_W + 1) / 2;
  localparam int N_IDX           = NORM_IDX + N_W;
  localparam int NDIV_STAGES     = 17;
  localparam int Q_IDX           = N_IDX + 1 + NDIV_STAGES;
  localparam int OUT_IDX         = Q_IDX + 1;

  typedef struct packed {
    logic               func;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
    logic signed [15:0] in_w;
    logic signed [15:0] code_y;
    logic signed [15:0] code_z;
    logic signed [15:0] code_w;
    logic               code_x_negative;
  } qtc_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
    logic signed [15:0] out_code_y;
    logic signed [15:0] out_code_z;
    logic signed [15:0] out_code_w;
    logic               out_x_negative;
  } qtc_out_t;

  // One decoded component as sign and magnitude (magnitude up to 32768)
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } qtc_comp_t;

  // Per-item control and encode results that ride along the pipeline
  typedef struct packed {
    logic        func;
    logic        enc_xneg;
    logic        dec_xneg;
    logic [15:0] enc_y;
    logic [15:0] enc_z;
    logic [15:0] enc_w;
  } qtc_side_t;

  // Decode components between the radicand and the normalizing divider
  typedef struct packed {
    qtc_comp_t   x;
    qtc_comp_t   y;
    qtc_comp_t   z;
    qtc_comp_t   w;
    logic [31:0] sum_yzw;
  } qtc_dec_t;

  // Unsaturated normalized quotient of one lane
  typedef struct packed {
    logic        neg;
    logic [16:0] quo;
  } qtc_nres_t;

endpackage

>>> rtl/quaternion_three_component_codec_core.sv
// Top level of the three-component quaternion codec.
// Depends on qtc_pkg, qtc_lane, qtc_isqrt and qtc_norm_div.

// The block takes one item per clock while in_ready is high and returns exactly
// one result per item, in order. Every item, encode or
// decode, runs through the same fixed-length pipeline; its length is set by
// the decode path: a 16-stage divide by scale in each of the y, z, w lanes,
// a 16-stage square root rebuilding x, a 31-stage square root of the norm and
// a 17-stage normalizing divide in four lanes. All stages move together and
// hold as a group while a finished result waits at the output register, so
// in_ready follows out_ready whenever the output register is full. scale is
// written through cfg_we/cfg_wdata and must change only while no item is in
// flight.
module quaternion_three_component_codec_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qtc_pkg::qtc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qtc_pkg::qtc_out_t  out_data,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata
);

  localparam int QI = qtc_pkg::Q_IDX;

  logic adv;
  logic [14:0] scale_r;

  logic [QI:0]          vld_r;
  qtc_pkg::qtc_side_t   side_r [0:QI];
  qtc_pkg::qtc_dec_t    dec_r  [qtc_pkg::RAD_IDX:qtc_pkg::N_IDX];

  logic [15:0]          enc_y, enc_z, enc_w;
  qtc_pkg::qtc_comp_t   dec_y, dec_z, dec_w;
  logic [31:0]          sq_y, sq_z, sq_w, sum_yzw;

  logic [qtc_pkg::RAD_W-1:0]  rad_r;
  logic [qtc_pkg::ROOT_W-1:0] x_root;
  logic [31:0]                norm2_r;
  logic [qtc_pkg::N_W-1:0]    norm;

  qtc_pkg::qtc_comp_t [3:0] ncomp;
  qtc_pkg::qtc_nres_t [3:0] nres;
  logic                     norm_zero;

  logic               out_valid_r;
  qtc_pkg::qtc_out_t  out_nxt, out_data_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= qtc_pkg::SCALE_RST;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // Component lanes
  qtc_lane u_lane_y (
    .clk(clk), .adv(adv), .scale(scale_r), .comp(in_data.in_y), .code(in_data.code_y),
    .enc_code(enc_y), .dec(dec_y), .dec_sq(sq_y)
  );
  qtc_lane u_lane_z (
    .clk(clk), .adv(adv), .scale(scale_r), .comp(in_data.in_z), .code(in_data.code_z),
    .enc_code(enc_z), .dec(dec_z), .dec_sq(sq_z)
  );
  qtc_lane u_lane_w (
    .clk(clk), .adv(adv), .scale(scale_r), .comp(in_data.in_w), .code(in_data.code_w),
    .enc_code(enc_w), .dec(dec_w), .dec_sq(sq_w)
  );

  assign sum_yzw = sq_y + sq_z + sq_w;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[QI-1:0], in_valid};
      out_valid_r <= vld_r[QI];
    end
  end

  // Side payload, decode components, radicand and norm
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].func     <= in_data.func;
      side_r[0].enc_xneg <= in_data.in_x[15];
      side_r[0].dec_xneg <= in_data.code_x_negative;
      side_r[0].enc_y    <= '0;
      side_r[0].enc_z    <= '0;
      side_r[0].enc_w    <= '0;
      side_r[1]          <= side_r[0];
      // Encode codes from the lanes' enc_r registers join the side payload here
      side_r[2].func     <= side_r[1].func;
      side_r[2].enc_xneg <= side_r[1].enc_xneg;
      side_r[2].dec_xneg <= side_r[1].dec_xneg;
      side_r[2].enc_y    <= enc_y;
      side_r[2].enc_z    <= enc_z;
      side_r[2].enc_w    <= enc_w;
      for (int p = 3; p <= QI; p++) begin
        side_r[p] <= side_r[p-1];
      end

      // Radicand 1.0 - y^2 - z^2 - w^2, clamped at zero
      rad_r <= (sum_yzw < qtc_pkg::ONE_Q30) ?
               qtc_pkg::RAD_W'(qtc_pkg::ONE_Q30 - sum_yzw) : '0;
      dec_r[qtc_pkg::RAD_IDX].x       <= '0;
      dec_r[qtc_pkg::RAD_IDX].y       <= dec_y;
      dec_r[qtc_pkg::RAD_IDX].z       <= dec_z;
      dec_r[qtc_pkg::RAD_IDX].w       <= dec_w;
      dec_r[qtc_pkg::RAD_IDX].sum_yzw <= sum_yzw;
      for (int p = qtc_pkg::RAD_IDX + 1; p <= qtc_pkg::N_IDX; p++) begin
        if (p != qtc_pkg::NORM_IDX) begin
          dec_r[p] <= dec_r[p-1];
        end
      end

      // Attach rebuilt x and form the squared norm
      dec_r[qtc_pkg::NORM_IDX].y       <= dec_r[qtc_pkg::XROOT_IDX].y;
      dec_r[qtc_pkg::NORM_IDX].z       <= dec_r[qtc_pkg::XROOT_IDX].z;
      dec_r[qtc_pkg::NORM_IDX].w       <= dec_r[qtc_pkg::XROOT_IDX].w;
      dec_r[qtc_pkg::NORM_IDX].sum_yzw <= dec_r[qtc_pkg::XROOT_IDX].sum_yzw;
      dec_r[qtc_pkg::NORM_IDX].x.mag   <= x_root;
      dec_r[qtc_pkg::NORM_IDX].x.neg   <= side_r[qtc_pkg::XROOT_IDX].dec_xneg;
      norm2_r <= 32'(32'(x_root) * 32'(x_root) + dec_r[qtc_pkg::XROOT_IDX].sum_yzw);
    end
  end

  qtc_isqrt #(.IN_W(qtc_pkg::RAD_W)) u_xroot (
    .clk(clk), .adv(adv), .val(rad_r), .root(x_root)
  );

  qtc_isqrt #(.IN_W(qtc_pkg::NSQ_IN_W)) u_nroot (
    .clk(clk), .adv(adv), .val({norm2_r, 30'd0}), .root(norm)
  );

  assign ncomp[0] = dec_r[qtc_pkg::N_IDX].x;
  assign ncomp[1] = dec_r[qtc_pkg::N_IDX].y;
  assign ncomp[2] = dec_r[qtc_pkg::N_IDX].z;
  assign ncomp[3] = dec_r[qtc_pkg::N_IDX].w;

  qtc_norm_div u_ndiv (
    .clk(clk), .adv(adv), .comp(ncomp), .norm(norm), .res(nres), .norm_zero(norm_zero)
  );

  // Clamp a normalized quotient to Q1.15
  function automatic logic [15:0] clamp_q15(input qtc_pkg::qtc_nres_t r);
    logic [16:0] neg_q;
    neg_q = 17'd0 - r.quo;
    if (r.neg) begin
      clamp_q15 = (r.quo >= 17'h08000) ? 16'h8000 : neg_q[15:0];
    end else begin
      clamp_q15 = (r.quo > 17'h07FFF) ? 16'h7FFF : r.quo[15:0];
    end
  endfunction

  // Merge lanes and select the encode or decode result
  always_comb begin
    out_nxt = '0;
    if (!side_r[QI].func) begin
      out_nxt.out_code_y     = side_r[QI].enc_y;
      out_nxt.out_code_z     = side_r[QI].enc_z;
      out_nxt.out_code_w     = side_r[QI].enc_w;
      out_nxt.out_x_negative = side_r[QI].enc_xneg;
    end else if (!norm_zero) begin
      out_nxt.out_x = clamp_q15(nres[0]);
      out_nxt.out_y = clamp_q15(nres[1]);
      out_nxt.out_z = clamp_q15(nres[2]);
      out_nxt.out_w = clamp_q15(nres[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result carries either decoded components or a sign flag, never both
  a_flag_only_on_encode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_x_negative |->
      out_data_r.out_x == 16'sd0 && out_data_r.out_y == 16'sd0 &&
      out_data_r.out_z == 16'sd0 && out_data_r.out_w == 16'sd0)
    else $error("decoded components on an encode result");

  // Rebuilt x never exceeds 1.0
  a_xroot_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[qtc_pkg::XROOT_IDX] && side_r[qtc_pkg::XROOT_IDX].func |->
      x_root <= qtc_pkg::ROOT_W'(32768))
    else $error("rebuilt x out of range");

  // Norm of a decoded item is never zero
  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[qtc_pkg::N_IDX] && side_r[qtc_pkg::N_IDX].func |-> norm != '0)
    else $error("zero norm on decode");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

>>> rtl/qtc_lane.sv
// One component lane: encode multiply and decode divide-by-scale pipeline.
// Depends on qtc_pkg for stage counts, code limits and the component type.
module qtc_lane (
  input  logic                clk,
  input  logic                adv,
  input  logic [14:0]         scale,
  input  logic signed [15:0]  comp,
  input  logic signed [15:0]  code,
  output logic [15:0]         enc_code,
  output qtc_pkg::qtc_comp_t  dec,
  output logic [31:0]         dec_sq
);

  localparam int NS = qtc_pkg::LANE_DIV_STAGES;

  logic [15:0] comp_u, code_u, comp_mag, code_mag;
  logic [30:0] prod_nxt, prod_r;
  logic        pneg_r;
  logic [15:0] enc_q;
  logic signed [31:0] enc_v, enc_sat;
  logic [15:0] enc_r;

  logic [30:0] rem_r   [0:NS];
  logic [15:0] quo_r   [0:NS];
  logic        neg_r   [0:NS];
  logic        sat_r   [0:NS];
  logic        zero_r  [0:NS];
  logic [30:0] rem_nxt [1:NS];
  logic [15:0] quo_nxt [1:NS];

  qtc_pkg::qtc_comp_t val_nxt, val_r, dec_r;
  logic [31:0] sq_r;

  assign comp_u   = comp;
  assign code_u   = code;
  assign comp_mag = comp_u[15] ? (16'd0 - comp_u) : comp_u;
  assign code_mag = code_u[15] ? (16'd0 - code_u) : code_u;
  assign prod_nxt = 31'(comp_mag) * 31'(scale);

  // Encode: truncate toward zero, then clamp to the code range
  always_comb begin
    enc_q = prod_r[30:15];
    enc_v = pneg_r ? -$signed({16'd0, enc_q}) : $signed({16'd0, enc_q});
    if (enc_v > qtc_pkg::CODE_HI) begin
      enc_sat = qtc_pkg::CODE_HI;
    end else if (enc_v < qtc_pkg::CODE_LO) begin
      enc_sat = qtc_pkg::CODE_LO;
    end else begin
      enc_sat = enc_v;
    end
  end

  // Decode: one quotient bit per stage, restoring division by scale
  always_comb begin
    logic [30:0] dv;
    dv = '0;
    for (int p = 0; p < NS; p++) begin
      dv = 31'(scale) << (NS - 1 - p);
      if (rem_r[p] >= dv) begin
        rem_nxt[p+1] = rem_r[p] - dv;
        quo_nxt[p+1] = quo_r[p] | (16'd1 << (NS - 1 - p));
      end else begin
        rem_nxt[p+1] = rem_r[p];
        quo_nxt[p+1] = quo_r[p];
      end
    end
  end

  // Clamp the quotient to Q1.15
  always_comb begin
    val_nxt.neg = neg_r[NS];
    if (zero_r[NS]) begin
      val_nxt.mag = 16'd0;
    end else if (sat_r[NS]) begin
      val_nxt.mag = neg_r[NS] ? 16'h8000 : 16'h7FFF;
    end else if (neg_r[NS]) begin
      val_nxt.mag = (quo_r[NS] > 16'h8000) ? 16'h8000 : quo_r[NS];
    end else begin
      val_nxt.mag = (quo_r[NS] > 16'h7FFF) ? 16'h7FFF : quo_r[NS];
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= prod_nxt;
      pneg_r    <= comp_u[15];
      enc_r     <= enc_sat[15:0];
      rem_r[0]  <= {code_mag, 15'd0};
      quo_r[0]  <= '0;
      neg_r[0]  <= code_u[15];
      sat_r[0]  <= code_mag >= {scale, 1'b0};
      zero_r[0] <= code_mag == 16'd0;
      for (int p = 1; p <= NS; p++) begin
        rem_r[p]  <= rem_nxt[p];
        quo_r[p]  <= quo_nxt[p];
        neg_r[p]  <= neg_r[p-1];
        sat_r[p]  <= sat_r[p-1];
        zero_r[p] <= zero_r[p-1];
      end
      val_r <= val_nxt;
      dec_r <= val_r;
      sq_r  <= 32'(val_r.mag) * 32'(val_r.mag);
    end
  end

  assign enc_code = enc_r;
  assign dec      = dec_r;
  assign dec_sq   = sq_r;

endmodule

>>> rtl/qtc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on no package; the input width sets the stage count.
module qtc_isqrt #(
  parameter int IN_W = 31
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [IN_W-1:0]         val,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int OUT_W = (IN_W + 1) / 2;
  localparam int TW    = 2 * OUT_W + 1;

  logic [IN_W-1:0]  rem_r    [1:OUT_W];
  logic [OUT_W-1:0] root_r   [1:OUT_W];
  logic [IN_W-1:0]  rem_cur  [0:OUT_W-1];
  logic [OUT_W-1:0] root_cur [0:OUT_W-1];
  logic [IN_W-1:0]  rem_nxt  [1:OUT_W];
  logic [OUT_W-1:0] root_nxt [1:OUT_W];

  // Select each stage's operands
  always_comb begin
    rem_cur[0]  = val;
    root_cur[0] = '0;
    for (int p = 1; p < OUT_W; p++) begin
      rem_cur[p]  = rem_r[p];
      root_cur[p] = root_r[p];
    end
  end

  // Try setting the next root bit: (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
  always_comb begin
    logic [TW-1:0] trial;
    trial = '0;
    for (int p = 0; p < OUT_W; p++) begin
      trial = (TW'(root_cur[p]) << (OUT_W - p)) + (TW'(1) << (2 * (OUT_W - 1 - p)));
      if (TW'(rem_cur[p]) >= trial) begin
        rem_nxt[p+1]  = IN_W'(TW'(rem_cur[p]) - trial);
        root_nxt[p+1] = root_cur[p] | (OUT_W'(1) << (OUT_W - 1 - p));
      end else begin
        rem_nxt[p+1]  = rem_cur[p];
        root_nxt[p+1] = root_cur[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 1; p <= OUT_W; p++) begin
        rem_r[p]  <= rem_nxt[p];
        root_r[p] <= root_nxt[p];
      end
    end
  end

  assign root = root_r[OUT_W];

endmodule

>>> rtl/qtc_norm_div.sv
// Four normalizing divider lanes sharing one pipelined copy of the norm.
// Depends on qtc_pkg for the stage count and the component and result types.
module qtc_norm_div (
  input  logic                                clk,
  input  logic                                adv,
  input  qtc_pkg::qtc_comp_t [3:0]            comp,
  input  logic [qtc_pkg::N_W-1:0]             norm,
  output qtc_pkg::qtc_nres_t [3:0]            res,
  output logic                                norm_zero
);

  localparam int NS = qtc_pkg::NDIV_STAGES;
  localparam int NW = qtc_pkg::N_W;

  logic [45:0]   rem_r   [0:NS][0:3];
  logic [16:0]   quo_r   [0:NS][0:3];
  logic          neg_r   [0:NS][0:3];
  logic [NW-1:0] n_r     [0:NS];
  logic [45:0]   rem_nxt [1:NS][0:3];
  logic [16:0]   quo_nxt [1:NS][0:3];

  // One quotient bit per stage in every lane
  always_comb begin
    logic [47:0] dv;
    dv = '0;
    for (int p = 0; p < NS; p++) begin
      dv = 48'(n_r[p]) << (NS - 1 - p);
      for (int l = 0; l < 4; l++) begin
        if (48'(rem_r[p][l]) >= dv) begin
          rem_nxt[p+1][l] = 46'(48'(rem_r[p][l]) - dv);
          quo_nxt[p+1][l] = quo_r[p][l] | (17'd1 << (NS - 1 - p));
        end else begin
          rem_nxt[p+1][l] = rem_r[p][l];
          quo_nxt[p+1][l] = quo_r[p][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[0] <= norm;
      for (int l = 0; l < 4; l++) begin
        rem_r[0][l] <= {comp[l].mag, 30'd0};
        quo_r[0][l] <= '0;
        neg_r[0][l] <= comp[l].neg;
      end
      for (int p = 1; p <= NS; p++) begin
        n_r[p] <= n_r[p-1];
        for (int l = 0; l < 4; l++) begin
          rem_r[p][l] <= rem_nxt[p][l];
          quo_r[p][l] <= quo_nxt[p][l];
          neg_r[p][l] <= neg_r[p-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      res[l].quo = quo_r[NS][l];
      res[l].neg = neg_r[NS][l];
    end
  end

  assign norm_zero = n_r[NS] == '0;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for quaternion_three_component_codec_core.
// Depends on qtc_pkg and the codec RTL; predicts every encode and decode result.
`timescale 1ns / 1ps

// Expected-result store with its own model of the codec arithmetic
class codec_scoreboard;
  qtc_pkg::qtc_out_t expected_results[$];
  logic [14:0]       scale;
  int                mismatches;
  int                checked;
  int                n_encode;
  int                n_decode;

  function new();
    scale      = qtc_pkg::SCALE_RST;
    mismatches = 0;
    checked    = 0;
    n_encode   = 0;
    n_decode   = 0;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function logic [15:0] quantize(logic signed [15:0] c);
    longint q;
    q = (longint'(c) * longint'(scale)) / 32768;
    return 16'(clamp(q, longint'(qtc_pkg::CODE_LO), longint'(qtc_pkg::CODE_HI)));
  endfunction

  function longint dequantize(logic signed [15:0] code);
    if (scale == 0) return (code > 0) ? 32767 : ((code < 0) ? -32768 : 0);
    return clamp((longint'(code) * 32768) / longint'(scale), -32768, 32767);
  endfunction

  function qtc_pkg::qtc_out_t predict_result(qtc_pkg::qtc_in_t d);
    qtc_pkg::qtc_out_t r;
    longint            c[4];
    longint            rad;
    longint            v;
    longint unsigned   norm2;
    longint unsigned   n;
    r = '0;
    if (d.func == 1'b0) begin
      r.out_code_y     = quantize(d.in_y);
      r.out_code_z     = quantize(d.in_z);
      r.out_code_w     = quantize(d.in_w);
      r.out_x_negative = d.in_x < 0;
    end else begin
      c[1] = dequantize(d.code_y);
      c[2] = dequantize(d.code_z);
      c[3] = dequantize(d.code_w);
      rad  = (64'sd1 <<< 30) - c[1] * c[1] - c[2] * c[2] - c[3] * c[3];
      c[0] = (rad > 0) ? longint'(int_sqrt(rad)) : 0;
      if (d.code_x_negative) c[0] = -c[0];
      norm2 = 0;
      for (int j = 0; j < 4; j++) norm2 += longint'(c[j] * c[j]);
      n = int_sqrt(norm2 << 30);
      if (n != 0) begin
        v = (c[0] * (64'sd1 <<< 30)) / longint'(n);
        r.out_x = 16'(clamp(v, -32768, 32767));
        v = (c[1] * (64'sd1 <<< 30)) / longint'(n);
        r.out_y = 16'(clamp(v, -32768, 32767));
        v = (c[2] * (64'sd1 <<< 30)) / longint'(n);
        r.out_z = 16'(clamp(v, -32768, 32767));
        v = (c[3] * (64'sd1 <<< 30)) / longint'(n);
        r.out_w = 16'(clamp(v, -32768, 32767));
      end
    end
    return r;
  endfunction

  function void note_item(qtc_pkg::qtc_in_t d);
    if (d.func) n_decode++;
    else n_encode++;
    expected_results.push_back(predict_result(d));
  endfunction

  function void check_result(qtc_pkg::qtc_out_t got);
    qtc_pkg::qtc_out_t exp_r;
    checked++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = expected_results.pop_front();
    if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
        got.out_z !== exp_r.out_z || got.out_w !== exp_r.out_w ||
        got.out_code_y !== exp_r.out_code_y || got.out_code_z !== exp_r.out_code_z ||
        got.out_code_w !== exp_r.out_code_w ||
        got.out_x_negative !== exp_r.out_x_negative) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at result %0d (scale %0d)", checked, scale);
        $display("  exp xyzw %0d %0d %0d %0d codes %0d %0d %0d neg %0d",
                 exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.out_w,
                 exp_r.out_code_y, exp_r.out_code_z, exp_r.out_code_w,
                 exp_r.out_x_negative);
        $display("  got xyzw %0d %0d %0d %0d codes %0d %0d %0d neg %0d",
                 got.out_x, got.out_y, got.out_z, got.out_w,
                 got.out_code_y, got.out_code_z, got.out_code_w, got.out_x_negative);
      end
    end
  endfunction
endclass

module tb_top;
  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  qtc_pkg::qtc_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  qtc_pkg::qtc_out_t out_data;
  logic              cfg_we;
  logic [14:0]       cfg_wdata;

  codec_scoreboard sb;
  logic            no_idle;
  logic            hold_req;
  logic            hold_done;
  int              hold_left;
  int              scales_used;

  quaternion_three_component_codec_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic idle_now();
    return !no_idle && ($urandom_range(99) < 37);
  endfunction

  // Check each result transfer, then pick out_ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) hold_done = 1'b0;
    if (out_valid && out_ready) sb.check_result(out_data);
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && !idle_now();
    end
  end

  // Offer one item and wait for its transfer
  task automatic send_item(qtc_pkg::qtc_in_t d);
    if (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Write scale once the pipeline is empty
  task automatic set_scale(logic [14:0] v);
    drain();
    repeat (90) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.scale = v;
    scales_used++;
  endtask

  function automatic qtc_pkg::qtc_in_t make_item(logic [14:0] sc);
    qtc_pkg::qtc_in_t d;
    logic [127:0]     rnd;
    int               lim;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    d = rnd[$bits(qtc_pkg::qtc_in_t)-1:0];
    d.func = 1'($urandom_range(1));
    // Mostly codes small enough to leave a positive radicand
    if (d.func && $urandom_range(99) < 65) begin
      lim = (sc / 2 > 0) ? sc / 2 : 1;
      d.code_y = 16'($urandom_range(2 * lim) - lim);
      d.code_z = 16'($urandom_range(2 * lim) - lim);
      d.code_w = 16'($urandom_range(2 * lim) - lim);
    end
    return d;
  endfunction

  function automatic qtc_pkg::qtc_in_t mk(logic f, int x, int y, int z, int w,
                                          int cy, int cz, int cw, logic neg);
    qtc_pkg::qtc_in_t d;
    d = {f, 16'(x), 16'(y), 16'(z), 16'(w), 16'(cy), 16'(cz), 16'(cw), neg};
    return d;
  endfunction

  initial begin
    logic [14:0] phase_scale [7];
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    scales_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, both operations, negative radicand
    send_item(mk(0, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
    send_item(mk(0, 32767, 32767, 32767, 32767, 0, 0, 0, 1));
    send_item(mk(0, 0, 0, 0, 0, -1, -1, -1, 1));
    send_item(mk(0, -1, 1, -1, 16384, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(mk(1, -1, -1, -1, -1, 32767, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, -32768, 0, 0, 1));
    send_item(mk(1, 0, 0, 0, 0, 32767, 32767, 32767, 0));
    send_item(mk(1, 0, 0, 0, 0, -32768, -32768, -32768, 1));
    send_item(mk(1, 0, 0, 0, 0, 16384, -16384, 16384, 1));
    send_item(mk(1, 0, 0, 0, 0, 1, -1, 1, 0));
    send_item(mk(1, 0, 0, 0, 0, 20000, 20000, 20000, 0));
    set_scale(15'd0);
    send_item(mk(0, -5, 32767, -32768, 7, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 5, -5, 0, 1));
    send_item(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));

    // Random phases over several scale settings, extremes included
    phase_scale = '{15'd32767, 15'd1, 15'd0, 15'd16384,
                    15'($urandom_range(32765) + 2), 15'd181, 15'd32767};
    for (int p = 0; p < 7; p++) begin
      set_scale(phase_scale[p]);
      for (int i = 0; i < 220; i++) begin
        no_idle  = (p == 2 && i >= 40 && i < 160);
        hold_req = (p == 0 && i == 30);
        if (p == 3 && i == 110) drain();
        send_item(make_item(phase_scale[p]));
      end
    end
    hold_req = 1'b0;
    no_idle  = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d encodes and %0d decodes over %0d scale settings",
             sb.n_encode, sb.n_decode, scales_used);
    $display("results checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #6000000;
    $display("timeout with %0d results outstanding", sb.expected_results.size());
    $display("tb_top: errors");
    $finish;
  end
endmodule
